// ===== hdl/rk4d_pkg.sv =====
// rk4d_pkg: shared widths, codes, structs and the microcode ROM of the
// Duffing RK4 step block. Depends on nothing; every hdl/ file imports it.
package rk4d_pkg;

  // Number formats
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = DATA_W + 1;      // multiplier operand, signed
  localparam int PROD_W    = 2 * OP_W;        // full product
  localparam int WIDE_W    = PROD_W + 1;      // headroom for rounding and sums
  localparam int ACC_W     = DATA_W + 2;      // f - damp - a1, exact
  localparam int WSUM_W    = DATA_W + 3;      // k1 + 2k2 + 2k3 + k4, exact

  typedef logic signed [DATA_W-1:0] q_t;

  localparam q_t Q_MAX = q_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam q_t Q_MIN = q_t'({1'b1, {(DATA_W-1){1'b0}}});

  // Configuration registers
  localparam int DT_W       = 17;
  localparam int ZETA_W     = 20;
  localparam int EPS_W      = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_RATIO   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CUBIC_STIFFNESS = CFG_IDX_W'(2);

  localparam logic [DT_W-1:0]   STEP_SIZE_RST = DT_W'(655);
  localparam logic [ZETA_W-1:0] DAMPING_RST   = ZETA_W'(6554);
  localparam logic [EPS_W-1:0]  CUBIC_RST     = EPS_W'(65536);

  typedef struct packed {
    logic [DT_W-1:0]   step_size;
    logic [ZETA_W-1:0] damping_ratio;
    logic [EPS_W-1:0]  cubic_stiffness;
  } cfg_t;

  // Divide by six, radix 16, one digit per cycle
  localparam int DIVISOR      = 6;
  localparam int DIV_ROUND    = DIVISOR / 2;
  localparam int DIV_DIGIT_W  = 4;
  localparam int DIV_DIGITS   = 9;
  localparam int DIV_W        = DIV_DIGIT_W * DIV_DIGITS;
  localparam int QUOT_W       = DATA_W + 1;
  localparam int REM_W        = 3;
  localparam int DIV_RECIP    = 43;            // floor(v*43/256) = floor(v/6), v < 96
  localparam int DIV_RECIP_W  = 6;
  localparam int DIV_RECIP_SH = 8;

  // Sequencer
  localparam int PC_W    = 4;
  localparam int STAGE_W = 2;

  typedef logic [PC_W-1:0]    pc_t;
  typedef logic [STAGE_W-1:0] stage_t;

  localparam stage_t STAGE_FIRST = stage_t'(0);
  localparam stage_t STAGE_LAST  = stage_t'(3);

  localparam pc_t PC_IDLE      = pc_t'(0);
  localparam pc_t PC_CALC_A    = pc_t'(1);
  localparam pc_t PC_MUL_SQ    = pc_t'(2);
  localparam pc_t PC_MUL_DAMP  = pc_t'(3);
  localparam pc_t PC_MUL_CU    = pc_t'(4);
  localparam pc_t PC_MUL_D1    = pc_t'(5);
  localparam pc_t PC_MUL_CUB   = pc_t'(6);
  localparam pc_t PC_WB_CUB    = pc_t'(7);
  localparam pc_t PC_ACC_SAT   = pc_t'(8);
  localparam pc_t PC_MUL_D2    = pc_t'(9);
  localparam pc_t PC_WB_D2     = pc_t'(10);
  localparam pc_t PC_DIV_START = pc_t'(11);
  localparam pc_t PC_DIV_WAIT  = pc_t'(12);
  localparam pc_t PC_OUT_WAIT  = pc_t'(13);
  localparam pc_t PC_COMMIT    = pc_t'(14);

  typedef enum logic [2:0] {
    COND_NONE, COND_ALWAYS, COND_NO_REQ, COND_STAGE_MORE, COND_DIV_BUSY, COND_OUT_FULL
  } cond_e;

  typedef enum logic [2:0] {MA_A1, MA_SQ, MA_ZETA, MA_DT, MA_EPS} mul_a_e;
  typedef enum logic [1:0] {MB_A1, MB_A2, MB_CU, MB_ACC} mul_b_e;
  typedef enum logic [2:0] {WB_NONE, WB_SQ, WB_DAMP, WB_CU, WB_D1, WB_CUB, WB_D2} wb_e;
  typedef enum logic [1:0] {ACC_NONE, ACC_PART, ACC_SAT} acc_e;

  // Datapath half of a control word
  typedef struct packed {
    logic   calc_a;
    mul_a_e mul_a;
    mul_b_e mul_b;
    logic   half_shift;
    wb_e    wb;
    acc_e   acc;
    logic   div_start;
    logic   commit;
  } dp_op_t;

  typedef struct packed {
    cond_e  cond;
    pc_t    target;
    dp_op_t op;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic   accept;
    stage_t stage;
    dp_op_t op;
  } ctrl_t;

  // One result
  typedef struct packed {
    q_t pos;
    q_t vel;
    q_t pos_lo;
    q_t pos_hi;
    q_t vel_lo;
    q_t vel_hi;
  } res_t;

  // Microcode ROM. A write-back takes the product issued in the step before.
  function automatic uword_t ucode_word(input pc_t pc);
    uword_t w;
    w        = '0;
    w.cond   = COND_NONE;
    w.target = PC_IDLE;
    unique case (pc)
      PC_IDLE: begin
        w.cond   = COND_NO_REQ;
        w.target = PC_IDLE;
      end
      PC_CALC_A: begin
        w.op.calc_a = 1'b1;
      end
      PC_MUL_SQ: begin
        w.op.mul_a = MA_A1;
        w.op.mul_b = MB_A1;
      end
      PC_MUL_DAMP: begin
        w.op.mul_a = MA_ZETA;
        w.op.mul_b = MB_A2;
        w.op.wb    = WB_SQ;
      end
      PC_MUL_CU: begin
        // damping product written back here takes the 2*zeta shift
        w.op.mul_a      = MA_SQ;
        w.op.mul_b      = MB_A1;
        w.op.half_shift = 1'b1;
        w.op.wb         = WB_DAMP;
      end
      PC_MUL_D1: begin
        w.op.mul_a = MA_DT;
        w.op.mul_b = MB_A2;
        w.op.wb    = WB_CU;
        w.op.acc   = ACC_PART;
      end
      PC_MUL_CUB: begin
        w.op.mul_a = MA_EPS;
        w.op.mul_b = MB_CU;
        w.op.wb    = WB_D1;
      end
      PC_WB_CUB: begin
        w.op.wb = WB_CUB;
      end
      PC_ACC_SAT: begin
        w.op.acc = ACC_SAT;
      end
      PC_MUL_D2: begin
        w.op.mul_a = MA_DT;
        w.op.mul_b = MB_ACC;
      end
      PC_WB_D2: begin
        w.op.wb  = WB_D2;
        w.cond   = COND_STAGE_MORE;
        w.target = PC_CALC_A;
      end
      PC_DIV_START: begin
        w.op.div_start = 1'b1;
      end
      PC_DIV_WAIT: begin
        w.cond   = COND_DIV_BUSY;
        w.target = PC_DIV_WAIT;
      end
      PC_OUT_WAIT: begin
        w.cond   = COND_OUT_FULL;
        w.target = PC_OUT_WAIT;
      end
      PC_COMMIT: begin
        w.op.commit = 1'b1;
        w.cond      = COND_ALWAYS;
        w.target    = PC_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/rk4d_div6.sv =====
// rk4d_div6: unsigned divide by six, one radix-16 digit per cycle.
// Depends on rk4d_pkg.
module rk4d_div6 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rk4d_pkg::DIV_W-1:0]  dividend_i,
  output logic                        busy_o,
  output logic [rk4d_pkg::QUOT_W-1:0] quot_o
);
  import rk4d_pkg::*;

  localparam int V_W   = REM_W + DIV_DIGIT_W;
  localparam int PR_W  = V_W + DIV_RECIP_W;
  localparam int CNT_W = $clog2(DIV_DIGITS + 1);

  localparam logic [DIV_RECIP_W-1:0] RECIP = DIV_RECIP_W'(DIV_RECIP);
  localparam logic [CNT_W-1:0]       CNT_LOAD = CNT_W'(DIV_DIGITS);
  localparam logic [CNT_W-1:0]       CNT_LAST = CNT_W'(1);

  logic                   busy_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [DIV_W-1:0]       num_q;
  logic [DIV_W-1:0]       quo_q;
  logic [REM_W-1:0]       rem_q;
  logic [V_W-1:0]         v;
  logic [PR_W-1:0]        prod;
  logic [DIV_DIGIT_W-1:0] digit;
  logic [V_W-1:0]         rem_full;

  // next digit: partial remainder stays below the divisor, so v < 96
  always_comb begin
    v        = {rem_q, num_q[DIV_W-1 -: DIV_DIGIT_W]};
    prod     = PR_W'(v) * PR_W'(RECIP);
    digit    = prod[DIV_RECIP_SH +: DIV_DIGIT_W];
    rem_full = v - V_W'(digit * DIVISOR);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_LOAD;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  // digit recurrence
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << DIV_DIGIT_W;
      quo_q <= {quo_q[DIV_W-DIV_DIGIT_W-1:0], digit};
      rem_q <= rem_full[REM_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q[QUOT_W-1:0];

endmodule

// ===== hdl/rk4d_datapath.sv =====
// rk4d_datapath: operand registers, shared multiplier with round and
// saturate, RK4 sums and state. Depends on rk4d_pkg and rk4d_div6.
module rk4d_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rk4d_pkg::ctrl_t             ctrl_i,
  input  rk4d_pkg::cfg_t              cfg_i,
  input  logic signed [rk4d_pkg::DATA_W-1:0] force_sample_i,
  input  logic                        restart_i,
  output logic                        div_busy_o,
  output rk4d_pkg::res_t              res_o
);
  import rk4d_pkg::*;

  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t HALF_FULL = wide_t'(1) <<< (FRAC_BITS - 1);
  localparam wide_t HALF_DAMP = wide_t'(1) <<< (FRAC_BITS - 2);

  function automatic q_t sat_q(input wide_t v);
    logic [WIDE_W-DATA_W:0] hi;
    hi = v[WIDE_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      return q_t'(v[DATA_W-1:0]);
    end else if (v[WIDE_W-1]) begin
      return Q_MIN;
    end
    return Q_MAX;
  endfunction

  // architectural state
  q_t pos_q, vel_q, pos_lo_q, pos_hi_q, vel_lo_q, vel_hi_q;
  // working registers
  q_t f_q, a1_q, a2_q, sq_q, damp_q, cu_q, cub_q, d1_q, d2_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [WSUM_W-1:0] s1_q, s2_q, term;
  logic signed [PROD_W-1:0] p_q;
  logic signed [OP_W-1:0]   op_a, op_b;

  q_t    wb_val, inc1, inc2, a1_calc, a2_calc;
  wide_t p_wide, rnd_full, rnd_damp;
  logic  mid_stage;

  logic [WSUM_W-1:0] mag1, mag2;
  logic [DIV_W-1:0]  div1_in, div2_in;
  logic [QUOT_W-1:0] quot1, quot2;
  logic              busy1, busy2;
  wide_t             qs1, qs2;
  res_t              res;

  // multiplier operand selection
  always_comb begin
    case (ctrl_i.op.mul_a)
      MA_A1:   op_a = OP_W'(a1_q);
      MA_SQ:   op_a = OP_W'(sq_q);
      MA_ZETA: op_a = OP_W'(cfg_i.damping_ratio);
      MA_DT:   op_a = OP_W'(cfg_i.step_size);
      MA_EPS:  op_a = OP_W'(cfg_i.cubic_stiffness);
      default: op_a = '0;
    endcase
    case (ctrl_i.op.mul_b)
      MB_A1:   op_b = OP_W'(a1_q);
      MB_A2:   op_b = OP_W'(a2_q);
      MB_CU:   op_b = OP_W'(cu_q);
      MB_ACC:  op_b = OP_W'(acc_q);
      default: op_b = '0;
    endcase
  end

  // round half up and saturate the product of the step before
  always_comb begin
    p_wide   = wide_t'(p_q);
    rnd_full = (p_wide + HALF_FULL) >>> FRAC_BITS;
    rnd_damp = (p_wide + HALF_DAMP) >>> (FRAC_BITS - 1);
    wb_val   = ctrl_i.op.half_shift ? sat_q(rnd_damp) : sat_q(rnd_full);
  end

  // stage operands: y, y + k/2, y + k/2, y + k
  always_comb begin
    if (ctrl_i.stage == STAGE_FIRST) begin
      inc1 = '0;
      inc2 = '0;
    end else if (ctrl_i.stage == STAGE_LAST) begin
      inc1 = d1_q;
      inc2 = d2_q;
    end else begin
      inc1 = d1_q >>> 1;
      inc2 = d2_q >>> 1;
    end
    a1_calc = sat_q(wide_t'(pos_q) + wide_t'(inc1));
    a2_calc = sat_q(wide_t'(vel_q) + wide_t'(inc2));
  end

  // increment weight 2 for the middle stages
  always_comb begin
    mid_stage = (ctrl_i.stage != STAGE_FIRST) && (ctrl_i.stage != STAGE_LAST);
    term      = mid_stage ? (WSUM_W'(wb_val) <<< 1) : WSUM_W'(wb_val);
  end

  // acceleration: partial sum, then subtract the cubic term and saturate
  always_comb begin
    case (ctrl_i.op.acc)
      ACC_PART: acc_d = ACC_W'(f_q) - ACC_W'(damp_q) - ACC_W'(a1_q);
      ACC_SAT:  acc_d = ACC_W'(sat_q(wide_t'(acc_q) - wide_t'(cub_q)));
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q   <= op_a * op_b;
    acc_q <= acc_d;
    if (ctrl_i.accept) begin
      f_q  <= force_sample_i;
      s1_q <= '0;
      s2_q <= '0;
    end
    if (ctrl_i.op.calc_a) begin
      a1_q <= a1_calc;
      a2_q <= a2_calc;
    end
    case (ctrl_i.op.wb)
      WB_SQ:   sq_q   <= wb_val;
      WB_DAMP: damp_q <= wb_val;
      WB_CU:   cu_q   <= wb_val;
      WB_CUB:  cub_q  <= wb_val;
      WB_D1: begin
        d1_q <= wb_val;
        s1_q <= s1_q + term;
      end
      WB_D2: begin
        d2_q <= wb_val;
        s2_q <= s2_q + term;
      end
      default: ;
    endcase
  end

  // |S| + 3 into the dividers
  always_comb begin
    mag1    = s1_q[WSUM_W-1] ? WSUM_W'(-s1_q) : WSUM_W'(s1_q);
    mag2    = s2_q[WSUM_W-1] ? WSUM_W'(-s2_q) : WSUM_W'(s2_q);
    div1_in = DIV_W'(mag1) + DIV_W'(DIV_ROUND);
    div2_in = DIV_W'(mag2) + DIV_W'(DIV_ROUND);
  end

  rk4d_div6 u_div_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.op.div_start),
    .dividend_i (div1_in),
    .busy_o     (busy1),
    .quot_o     (quot1)
  );

  rk4d_div6 u_div_vel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.op.div_start),
    .dividend_i (div2_in),
    .busy_o     (busy2),
    .quot_o     (quot2)
  );

  assign div_busy_o = busy1 | busy2;

  // new state and extremes
  always_comb begin
    qs1        = wide_t'(quot1);
    qs2        = wide_t'(quot2);
    res.pos    = sat_q(wide_t'(pos_q) + (s1_q[WSUM_W-1] ? -qs1 : qs1));
    res.vel    = sat_q(wide_t'(vel_q) + (s2_q[WSUM_W-1] ? -qs2 : qs2));
    res.pos_lo = (res.pos < pos_lo_q) ? res.pos : pos_lo_q;
    res.pos_hi = (res.pos > pos_hi_q) ? res.pos : pos_hi_q;
    res.vel_lo = (res.vel < vel_lo_q) ? res.vel : vel_lo_q;
    res.vel_hi = (res.vel > vel_hi_q) ? res.vel : vel_hi_q;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      vel_q    <= '0;
      pos_lo_q <= '0;
      pos_hi_q <= '0;
      vel_lo_q <= '0;
      vel_hi_q <= '0;
    end else if (ctrl_i.accept) begin
      if (restart_i) begin
        pos_q <= '0;
        vel_q <= '0;
      end
    end else if (ctrl_i.op.commit) begin
      pos_q    <= res.pos;
      vel_q    <= res.vel;
      pos_lo_q <= res.pos_lo;
      pos_hi_q <= res.pos_hi;
      vel_lo_q <= res.vel_lo;
      vel_hi_q <= res.vel_hi;
    end
  end

  // extremes start at zero, so they always bracket it
  a_extremes_bracket_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_lo_q <= 0) && (pos_hi_q >= 0) && (vel_lo_q <= 0) && (vel_hi_q >= 0))
    else $error("running extremes no longer bracket zero");

  a_commit_after_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op.commit |-> !div_busy_o)
    else $error("state committed while divide by six still running");

endmodule

// ===== hdl/rk4d_sequencer.sv =====
// rk4d_sequencer: microcode step counter, RK4 stage counter and jump
// conditions. Depends on rk4d_pkg (control word ROM and types).
module rk4d_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_full_i,
  input  logic            div_busy_i,
  output logic            in_stall_o,
  output rk4d_pkg::ctrl_t ctrl_o
);
  import rk4d_pkg::*;

  pc_t    pc_q, pc_d;
  stage_t stage_q, stage_d;
  uword_t uw;
  logic   take;
  logic   idle;

  // fetch
  assign uw   = ucode_word(pc_q);
  assign idle = (pc_q == PC_IDLE);

  // jump condition
  always_comb begin
    unique case (uw.cond)
      COND_NONE:       take = 1'b0;
      COND_ALWAYS:     take = 1'b1;
      COND_NO_REQ:     take = !in_valid_i;
      COND_STAGE_MORE: take = (stage_q != STAGE_LAST);
      COND_DIV_BUSY:   take = div_busy_i;
      COND_OUT_FULL:   take = out_full_i;
      default:         take = 1'b0;
    endcase
  end

  // next step and stage; the stage loop step also advances the stage
  always_comb begin
    pc_d    = take ? uw.target : pc_t'(pc_q + 1'b1);
    stage_d = stage_q;
    if (idle && in_valid_i) begin
      stage_d = STAGE_FIRST;
    end else if (uw.cond == COND_STAGE_MORE) begin
      stage_d = stage_t'(stage_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= PC_IDLE;
      stage_q <= STAGE_FIRST;
    end else begin
      pc_q    <= pc_d;
      stage_q <= stage_d;
    end
  end

  // control out
  always_comb begin
    ctrl_o.accept = idle && in_valid_i;
    ctrl_o.stage  = stage_q;
    ctrl_o.op     = uw.op;
  end

  assign in_stall_o = !idle;

endmodule

// ===== hdl/rk4_duffing_oscillator_step.sv =====
// rk4_duffing_oscillator_step: top level of the Duffing RK4 step block.
// Holds the configuration registers and the result register.
// Depends on rk4d_pkg, rk4d_sequencer and rk4d_datapath.
//
//  channel  direction  handshake               payload
//  in       request    in_valid_i/in_stall_o   force_sample_i, restart_i
//  out      result     out_valid_o/out_stall_i displacement_o, velocity_o,
//                                              displacement/velocity_min/max_o
//  cfg      write      cfg_we_i                cfg_index_i, cfg_data_i
//
// An accepted request runs through the microcode steps below and then shows its
// result; a new request is taken only once the block is back in its idle step.
// The shared multiplier sets the step sequence: ten microcode steps per RK4 stage,
// four stages, then a start step, wait steps for the two radix-16 divide-by-six
// units (nine digits each) and the output check and commit steps.
// Reset (rst_ni low, asynchronous) restores register defaults and zeroes state.
// A stalled result holds the block in its output wait step until taken.
module rk4_duffing_oscillator_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [rk4d_pkg::DATA_W-1:0]  force_sample_i,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [rk4d_pkg::DATA_W-1:0]  displacement_o,
  output logic signed [rk4d_pkg::DATA_W-1:0]  velocity_o,
  output logic signed [rk4d_pkg::DATA_W-1:0]  displacement_min_o,
  output logic signed [rk4d_pkg::DATA_W-1:0]  displacement_max_o,
  output logic signed [rk4d_pkg::DATA_W-1:0]  velocity_min_o,
  output logic signed [rk4d_pkg::DATA_W-1:0]  velocity_max_o,
  input  logic                                cfg_we_i,
  input  logic [rk4d_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rk4d_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import rk4d_pkg::*;

  cfg_t  cfg_q;
  ctrl_t ctrl;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q;
  logic  out_full;
  logic  div_busy;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size       <= STEP_SIZE_RST;
      cfg_q.damping_ratio   <= DAMPING_RST;
      cfg_q.cubic_stiffness <= CUBIC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STEP_SIZE:       cfg_q.step_size       <= cfg_data_i[DT_W-1:0];
        CFG_DAMPING_RATIO:   cfg_q.damping_ratio   <= cfg_data_i[ZETA_W-1:0];
        CFG_CUBIC_STIFFNESS: cfg_q.cubic_stiffness <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_full = out_valid_q && out_stall_i;

  rk4d_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_full_i (out_full),
    .div_busy_i (div_busy),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  rk4d_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cfg_i          (cfg_q),
    .force_sample_i (force_sample_i),
    .restart_i      (restart_i),
    .div_busy_o     (div_busy),
    .res_o          (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.op.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.op.commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign displacement_o     = out_q.pos;
  assign velocity_o         = out_q.vel;
  assign displacement_min_o = out_q.pos_lo;
  assign displacement_max_o = out_q.pos_hi;
  assign velocity_min_o     = out_q.vel_lo;
  assign velocity_max_o     = out_q.vel_hi;

  a_commit_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.op.commit |-> !out_valid_q)
    else $error("result committed over one not yet taken");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.op.commit))
    else $error("result valid without a commit");

  a_one_request_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while one still in progress");

endmodule

// ===== tb/tb_rk4_duffing_oscillator_step.sv =====
// Self-checking testbench for rk4_duffing_oscillator_step: directed and random requests,
// each result checked against a predictor of the saturating Q16.16 RK4 Duffing step.
// Depends on rk4d_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_rk4_duffing_oscillator_step;
  import rk4d_pkg::*;

  localparam int SEGMENTS     = 9;
  localparam int SEG_ITEMS    = 55;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 60;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

  // Index 3 maps to no register
  localparam cfg_idx_t CFG_UNMAPPED = cfg_idx_t'(3);

  // One directed request, optionally preceded by a register update
  typedef struct {
    logic      new_cfg;
    cfg_word_t dt;
    cfg_word_t zeta;
    cfg_word_t eps;
    q_t        exc;
    logic      restart;
    logic      zero_result;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  q_t        force_sample_i;
  logic      restart_i;
  logic      out_valid_o;
  logic      out_stall_i;
  q_t        displacement_o;
  q_t        velocity_o;
  q_t        displacement_min_o;
  q_t        displacement_max_o;
  q_t        velocity_min_o;
  q_t        velocity_max_o;
  logic      cfg_we_i;
  cfg_idx_t  cfg_index_i;
  cfg_word_t cfg_data_i;

  // Predictor copy of the registers and oscillator state
  logic [DT_W-1:0]   dt_reg;
  logic [ZETA_W-1:0] zeta_reg;
  logic [EPS_W-1:0]  eps_reg;
  q_t disp_now, vel_now, disp_lo, disp_hi, vel_lo, vel_hi;

  res_t     results_due[$];
  res_t     oldest_due;
  dir_row_t dir_plan[$];
  int       fail_count;
  int       results_taken;
  int       hold_at;
  logic     hold_done;
  int       sender_gap_pct;
  int       receiver_gap_pct;
  int       quiet_cycles;

  rk4_duffing_oscillator_step u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .force_sample_i     (force_sample_i),
    .restart_i          (restart_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .displacement_o     (displacement_o),
    .velocity_o         (velocity_o),
    .displacement_min_o (displacement_min_o),
    .displacement_max_o (displacement_max_o),
    .velocity_min_o     (velocity_min_o),
    .velocity_max_o     (velocity_max_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic q_t sat_q(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return q_t'(v);
  endfunction

  // exact product, shift with round half up, saturate
  function automatic q_t mul_round(longint a, longint b, int sh);
    return sat_q((a * b + (longint'(1) << (sh - 1))) >>> sh);
  endfunction

  function automatic q_t duffing_accel(q_t f, q_t y1, q_t y2);
    longint damp, sq, cu, cub;
    damp = mul_round(zeta_reg, y2, FRAC_BITS - 1);   // 2*zeta*y2
    sq   = mul_round(y1, y1, FRAC_BITS);
    cu   = mul_round(sq, y1, FRAC_BITS);
    cub  = mul_round(eps_reg, cu, FRAC_BITS);
    return sat_q(longint'(f) - damp - longint'(y1) - cub);
  endfunction

  // divide the weighted sum by six, ties away from zero, then accumulate
  function automatic q_t advance_by(q_t y, longint s);
    longint mag, q;
    mag = (s < 0) ? -s : s;
    q   = (mag + 3) / 6;
    if (s < 0) q = -q;
    return sat_q(longint'(y) + q);
  endfunction

  function automatic res_t duffing_rk4_step(q_t f, logic restart);
    q_t   y1, y2, a1, a2;
    q_t   d1[4];
    q_t   d2[4];
    res_t r;
    if (restart) begin
      disp_now = '0;
      vel_now  = '0;
    end
    y1 = disp_now;
    y2 = vel_now;
    for (int k = 0; k < 4; k++) begin
      if (k == 0) begin
        a1 = y1;
        a2 = y2;
      end else if (k < 3) begin
        // half increments floor towards minus infinity
        a1 = sat_q(longint'(y1) + (longint'(d1[k-1]) >>> 1));
        a2 = sat_q(longint'(y2) + (longint'(d2[k-1]) >>> 1));
      end else begin
        a1 = sat_q(longint'(y1) + longint'(d1[2]));
        a2 = sat_q(longint'(y2) + longint'(d2[2]));
      end
      d1[k] = mul_round(dt_reg, a2, FRAC_BITS);
      d2[k] = mul_round(dt_reg, duffing_accel(f, a1, a2), FRAC_BITS);
    end
    disp_now = advance_by(y1, longint'(d1[0]) + 2 * longint'(d1[1]) +
                              2 * longint'(d1[2]) + longint'(d1[3]));
    vel_now  = advance_by(y2, longint'(d2[0]) + 2 * longint'(d2[1]) +
                              2 * longint'(d2[2]) + longint'(d2[3]));
    if (disp_now > disp_hi) disp_hi = disp_now;
    if (disp_now < disp_lo) disp_lo = disp_now;
    if (vel_now > vel_hi) vel_hi = vel_now;
    if (vel_now < vel_lo) vel_lo = vel_now;
    r.pos    = disp_now;
    r.vel    = vel_now;
    r.pos_lo = disp_lo;
    r.pos_hi = disp_hi;
    r.vel_lo = vel_lo;
    r.vel_hi = vel_hi;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic new_cfg, cfg_word_t dt, cfg_word_t zeta,
                                      cfg_word_t eps, q_t exc, logic restart,
                                      logic zero_result);
    dir_row_t r;
    r.new_cfg     = new_cfg;
    r.dt          = dt;
    r.zeta        = zeta;
    r.eps         = eps;
    r.exc         = exc;
    r.restart     = restart;
    r.zero_result = zero_result;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  // Called at a falling edge; valid drops at the falling edge after acceptance
  // and the task returns at a later falling edge.
  task automatic send_request(q_t exc, logic restart, logic zero_result);
    res_t step_res;
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    force_sample_i <= exc;
    restart_i      <= restart;
    do @(posedge clk_i); while (in_stall_o);
    step_res = duffing_rk4_step(exc, restart);
    if (zero_result) step_res = '0;
    results_due.push_back(step_res);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it
  task automatic write_reg(cfg_idx_t idx, cfg_word_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_STEP_SIZE:       dt_reg   = data[DT_W-1:0];
      CFG_DAMPING_RATIO:   zeta_reg = data[ZETA_W-1:0];
      CFG_CUBIC_STIFFNESS: eps_reg  = data[EPS_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_settings(cfg_word_t dt, cfg_word_t zeta, cfg_word_t eps);
    write_reg(CFG_STEP_SIZE, dt);
    write_reg(CFG_DAMPING_RATIO, zeta);
    write_reg(CFG_CUBIC_STIFFNESS, eps);
    // unmapped index must leave every register alone
    write_reg(CFG_UNMAPPED, cfg_word_t'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Sender pauses until every outstanding request has been answered
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_taken >= hold_at) begin
        // long hold-off so the block fills and stalls its input
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < receiver_gap_pct);
      end
    end
  end

  task automatic check_field(string name, q_t want_v, q_t got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_taken++;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none got displacement %0d",
                 $time, displacement_o);
        fail_count++;
      end else begin
        oldest_due = results_due.pop_front();
        check_field("displacement", oldest_due.pos, displacement_o);
        check_field("velocity", oldest_due.vel, velocity_o);
        check_field("displacement_min", oldest_due.pos_lo, displacement_min_o);
        check_field("displacement_max", oldest_due.pos_hi, displacement_max_o);
        check_field("velocity_min", oldest_due.vel_lo, velocity_min_o);
        check_field("velocity_max", oldest_due.vel_hi, velocity_max_o);
      end
    end
  end

  // Watchdog: cycles without any handshake on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    cfg_word_t dt_w, zeta_w, eps_w;
    q_t        exc;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    force_sample_i   = '0;
    restart_i        = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    fail_count       = 0;
    results_taken    = 0;
    hold_done        = 1'b0;
    quiet_cycles     = 0;
    sender_gap_pct   = 10;
    receiver_gap_pct = 57;
    dt_reg   = STEP_SIZE_RST;
    zeta_reg = DAMPING_RST;
    eps_reg  = CUBIC_RST;
    disp_now = '0; vel_now = '0;
    disp_lo  = '0; disp_hi = '0;
    vel_lo   = '0; vel_hi  = '0;

    // directed: reset defaults, force extremes, register extremes, zero step
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, '0, 1'b0, 1'b1));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, '0, 1'b1, 1'b1));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, Q_MAX, 1'b0, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, Q_MAX, 1'b0, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, Q_MIN, 1'b0, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, Q_MIN, 1'b1, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, 32'sh0001_0000, 1'b0, 1'b0));
    // undamped, linear, unit step: velocity runs into saturation
    dir_plan.push_back(mk_row(1'b1, 65536, 0, 0, Q_MAX, 1'b0, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, Q_MAX, 1'b0, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, Q_MAX, 1'b0, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, Q_MIN, 1'b0, 1'b0));
    // every register at the top of its random-test range
    dir_plan.push_back(mk_row(1'b1, 65536, 655360, 655360, Q_MIN, 1'b1, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, Q_MAX, 1'b0, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, -32'sd1, 1'b0, 1'b0));
    // zero step holds the state; restart with zero step gives zero state
    dir_plan.push_back(mk_row(1'b1, 0, 6554, 65536, Q_MAX, 1'b0, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, Q_MIN, 1'b1, 1'b0));
    // smallest step
    dir_plan.push_back(mk_row(1'b1, 1, 655360, 0, Q_MAX, 1'b0, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, Q_MIN, 1'b0, 1'b0));
    // all data bits set, step size keeps its low 17 bits
    dir_plan.push_back(mk_row(1'b1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                              32'sh0002_0000, 1'b1, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, 32'sh8000_0001, 1'b0, 1'b0));
    dir_plan.push_back(mk_row(1'b1, 655, 6554, 65536, '0, 1'b1, 1'b0));
    dir_plan.push_back(mk_row(1'b0, '0, '0, '0, 32'sh0010_0000, 1'b0, 1'b0));
    hold_at = dir_plan.size() + 4 * SEG_ITEMS + 20;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_plan[i]) begin
      if (dir_plan[i].new_cfg) begin
        wait_drained();
        apply_settings(dir_plan[i].dt, dir_plan[i].zeta, dir_plan[i].eps);
      end
      send_request(dir_plan[i].exc, dir_plan[i].restart, dir_plan[i].zero_result);
    end

    // random: three idling regimes, three register settings each
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      case (seg / 3)
        0: begin sender_gap_pct = 10; receiver_gap_pct = 57; end
        1: begin sender_gap_pct = 57; receiver_gap_pct = 10; end
        default: begin sender_gap_pct = 0; receiver_gap_pct = 0; end
      endcase
      case (seg)
        0: begin dt_w = 655; zeta_w = 6554; eps_w = 65536; end
        2: begin dt_w = 65536; zeta_w = 655360; eps_w = 655360; end
        3: begin dt_w = 1; zeta_w = 0; eps_w = 0; end
        6: begin
          dt_w   = cfg_word_t'($urandom);
          zeta_w = cfg_word_t'($urandom);
          eps_w  = cfg_word_t'($urandom);
        end
        default: begin
          dt_w   = cfg_word_t'($urandom_range(1, 65536));
          zeta_w = cfg_word_t'($urandom_range(0, 655360));
          eps_w  = cfg_word_t'($urandom_range(0, 655360));
        end
      endcase
      apply_settings(dt_w, zeta_w, eps_w);
      repeat (SEG_ITEMS) begin
        // mostly moderate forcing so the trajectory evolves, some full-range noise
        if ($urandom_range(0, 4) == 0) begin
          exc = q_t'($urandom);
        end else begin
          exc = q_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        end
        send_request(exc, $urandom_range(0, 19) == 0, 1'b0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
